FILE: src/ckhc_pkg.sv
// ----------------------------------------------------------------------------
// ckhc_pkg
// Types, constants and table functions for the keyed header check.
// ----------------------------------------------------------------------------
package ckhc_pkg;

    localparam int HDR_LEN    = 14;
    localparam int HALF_LEN   = 7;
    localparam int CIPHER_W   = 56;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_CIPHER_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CIPHER_HIGH = 1'b1;

    localparam logic [31:0] CRC32_POLY  = 32'h04C1_1DB7;
    localparam logic [15:0] CRC16_POLY  = 16'h1021;
    localparam logic [15:0] CRC16_START = 16'h07A2;

    // expected plaintext header, byte 0 first
    localparam logic [7:0] EXPECTED_TEXT [HDR_LEN] = '{
        8'h42, 8'h69, 8'h6E, 8'h61, 8'h72, 8'h79, 8'h52,
        8'h65, 8'h73, 8'h65, 8'h61, 8'h72, 8'h63, 8'h68
    };

    // key state carried down the cell row
    typedef struct packed {
        logic [15:0] key;
        logic        match;
        logic [15:0] folded;
    } ckhc_token_t;

    // msb-first crc-32 table entry
    function automatic logic [31:0] crc32_entry(input logic [7:0] v);
        logic [31:0] r;
        r = {v, 24'h0};
        for (int k = 0; k < 8; k++)
        begin
            if (r[31])
                r = {r[30:0], 1'b0} ^ CRC32_POLY;
            else
                r = {r[30:0], 1'b0};
        end
        return r;
    endfunction

    // decryption table entry, seeded crc-16 step over data byte v
    function automatic logic [15:0] crc16_entry(input logic [7:0] v);
        logic [15:0] acc;
        logic [15:0] dat;
        acc = CRC16_START;
        dat = {v, 8'h0};
        for (int k = 0; k < 8; k++)
        begin
            if (acc[15] ^ dat[15])
                acc = {acc[14:0], 1'b0} ^ CRC16_POLY;
            else
                acc = {acc[14:0], 1'b0};
            dat = {dat[14:0], 1'b0};
        end
        return acc;
    endfunction

endpackage

FILE: src/ckhc_if.sv
// ----------------------------------------------------------------------------
// ckhc interfaces
// Key byte stream, result stream and configuration write channel.
// ----------------------------------------------------------------------------
interface ckhc_key_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_byte;
    logic       final_byte;

    modport source (output valid, output key_byte, output final_byte, input ready);
    modport sink   (input valid, input key_byte, input final_byte, output ready);
endinterface

interface ckhc_result_if;
    logic        valid;
    logic        ready;
    logic        header_match;
    logic [15:0] folded_key;

    modport source (output valid, output header_match, output folded_key, input ready);
    modport sink   (input valid, input header_match, input folded_key, output ready);
endinterface

interface ckhc_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [55:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/ckhc_crc_front.sv
// ----------------------------------------------------------------------------
// ckhc_crc_front
// Running crc-32 over key bytes; folds it into a seed token on the final byte.
// ----------------------------------------------------------------------------
module ckhc_crc_front
    import ckhc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic        load,
    input  logic [7:0]  key_byte,
    input  logic        final_byte,
    output logic        seed_valid,
    output ckhc_token_t seed_tok
);

    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    logic [31:0] crc_upd;
    logic        seed_valid_reg;
    logic        seed_valid_next;
    ckhc_token_t seed_tok_reg;
    ckhc_token_t seed_tok_next;

    always_comb
    begin
        crc_upd  = {crc_reg[23:0], 8'h0} ^ crc32_entry(key_byte ^ crc_reg[31:24]);
        crc_next = crc_reg;
        if (take)
            crc_next = final_byte ? 32'h0 : crc_upd;

        seed_valid_next = seed_valid_reg;
        if (load)
            seed_valid_next = take && final_byte;

        seed_tok_next.folded = crc_upd[31:16] ^ crc_upd[15:0];
        seed_tok_next.key    = crc_upd[31:16] ^ crc_upd[15:0];
        seed_tok_next.match  = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg        <= '0;
            seed_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg        <= crc_next;
            seed_valid_reg <= seed_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && take && final_byte)
            seed_tok_reg <= seed_tok_next;
    end

    assign seed_valid = seed_valid_reg;
    assign seed_tok   = seed_tok_reg;

endmodule

FILE: src/ckhc_cell.sv
// ----------------------------------------------------------------------------
// ckhc_cell
// One decryption step: checks one header byte and advances the key.
// ----------------------------------------------------------------------------
module ckhc_cell
    import ckhc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  logic        in_valid,
    input  ckhc_token_t in_tok,
    input  logic [7:0]  enc_byte,
    input  logic [7:0]  expect_byte,
    output logic        out_valid,
    output ckhc_token_t out_tok
);

    logic        valid_reg;
    logic        valid_next;
    ckhc_token_t tok_reg;
    ckhc_token_t tok_next;
    logic [7:0]  lo;
    logic [7:0]  hi;

    always_comb
    begin
        lo              = in_tok.key[7:0];
        hi              = in_tok.key[15:8];
        tok_next.folded = in_tok.folded;
        tok_next.match  = in_tok.match && ((enc_byte ^ lo) == expect_byte);
        tok_next.key    = crc16_entry(hi ^ enc_byte) ^ {lo, 8'h0};
        valid_next      = load ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
            tok_reg <= tok_next;
    end

    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;

endmodule

FILE: src/crc_keyed_header_check.sv
// ----------------------------------------------------------------------------
// crc_keyed_header_check
// Folds a crc-32 of each candidate key and checks a decrypted header with it.
// ----------------------------------------------------------------------------
//  channel     | dir | payload                     | request completes
//  key_in      | in  | key_byte, final_byte        | valid && ready
//  result_out  | out | header_match, folded_key    | valid && ready
//  cfg         | in  | index, data (56 bits)       | valid && ready
//
// one key byte per cycle while key_in.ready is high; the crc register closes its loop
// through combinational update logic; a result passes the fold stage and then the 14 cells
// the cell row works as an elastic pipeline, so a stall on result_out only
// holds key_in once every stage is full
// reset clears the crc, the stage valids and the cipher registers
// ----------------------------------------------------------------------------
module crc_keyed_header_check
    import ckhc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    ckhc_key_if.sink      key_in,
    ckhc_result_if.source result_out,
    ckhc_cfg_if.sink      cfg
);

    localparam int STAGES = HDR_LEN + 1;

    logic [CIPHER_W-1:0] cipher_low_reg;
    logic [CIPHER_W-1:0] cipher_high_reg;
    logic [STAGES-1:0]   stage_valid;
    logic [STAGES-1:0]   stage_ready;
    ckhc_token_t         stage_tok [STAGES];
    logic                take;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cipher_low_reg  <= '0;
            cipher_high_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_CIPHER_LOW:  cipher_low_reg  <= cfg.data;
                CFG_CIPHER_HIGH: cipher_high_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // a stage can load when it is empty or its successor loads
    always_comb
    begin
        stage_ready[STAGES-1] = !stage_valid[STAGES-1] || result_out.ready;
        for (int k = STAGES - 2; k >= 0; k--)
            stage_ready[k] = !stage_valid[k] || stage_ready[k+1];
    end

    assign key_in.ready = stage_ready[0];
    assign take         = key_in.valid && key_in.ready;

    ckhc_crc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .load       (stage_ready[0]),
        .key_byte   (key_in.key_byte),
        .final_byte (key_in.final_byte),
        .seed_valid (stage_valid[0]),
        .seed_tok   (stage_tok[0])
    );

    for (genvar i = 0; i < HDR_LEN; i++)
    begin : g_cell
        logic [7:0] enc;
        if (i < HALF_LEN)
        begin : g_low
            assign enc = cipher_low_reg[8*i +: 8];
        end
        else
        begin : g_high
            assign enc = cipher_high_reg[8*(i-HALF_LEN) +: 8];
        end

        ckhc_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .load        (stage_ready[i+1]),
            .in_valid    (stage_valid[i]),
            .in_tok      (stage_tok[i]),
            .enc_byte    (enc),
            .expect_byte (EXPECTED_TEXT[i]),
            .out_valid   (stage_valid[i+1]),
            .out_tok     (stage_tok[i+1])
        );
    end

    assign result_out.valid        = stage_valid[STAGES-1];
    assign result_out.header_match = stage_tok[STAGES-1].match;
    assign result_out.folded_key   = stage_tok[STAGES-1].folded;

    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !key_in.ready |-> (&stage_valid) && !result_out.ready)
        else $error("input blocked while the cell row has room");

    a_final_seeds: assert property (@(posedge clk) disable iff (!rst_n)
        take && key_in.final_byte |=> stage_valid[0])
        else $error("final byte did not produce a seed");

    a_plain_no_seed: assert property (@(posedge clk) disable iff (!rst_n)
        take && !key_in.final_byte && !stage_valid[0] |=> !stage_valid[0])
        else $error("non-final byte produced a seed");

endmodule
